>>> rtl/core/spq_pkg.sv
`default_nettype none
package spq_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned PRIO_W  = 16;
   localparam int unsigned ENTRY_W = VALUE_W + PRIO_W;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FRONT_RD,
      ST_FRONT_WAIT
   } state_type;

endpackage
`default_nettype wire

>>> rtl/core/spq_ram.sv
`default_nettype none
module spq_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/sorted_priority_queue_core.sv
// A dequeue or a rejected command goes through ST_FRONT_RD to ST_FRONT_WAIT, where
// its result is valid. An enqueue first walks the entries it passes in ST_SCAN_RD
// and ST_SCAN_CMP, one RAM read and one compare per entry walked, then goes on to ST_FRONT_RD.
// One transaction at a time; busy falls the cycle after the result. The receiver
// cannot stall results.
// Reset clears the sequencer and the count and sets the front slot; RAM is not cleared.
`default_nettype none
module sorted_priority_queue_core
   import spq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_cmd,
   input  wire logic signed [VALUE_W-1:0]    req_item_value,
   input  wire logic        [PRIO_W-1:0]     req_item_priority,
   output logic                              rsp_valid,
   output logic                              rsp_done_res,
   output logic signed [VALUE_W-1:0]         rsp_front_value,
   output logic        [PRIO_W-1:0]          rsp_front_priority,
   output logic        [$clog2(DEPTH+1)-1:0] rsp_occupancy,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DepthW   = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DepthC   = CW'(DEPTH);

   function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DepthW) begin
         s = s - DepthW;
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] a);
      return (a == '0) ? LastSlot : a - AW'(1);
   endfunction

   state_type             state_ff, state_in;
   logic [AW-1:0]         front_ff, front_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         k_ff, k_in;
   logic                  done_ff, done_in;
   logic [VALUE_W-1:0]    val_ff, val_in;
   logic [PRIO_W-1:0]     pri_ff, pri_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [ENTRY_W-1:0]    rd_data;

   logic [AW-1:0]         scan_slot;
   logic [AW-1:0]         dst_slot;
   logic [ENTRY_W-1:0]    new_entry;

   spq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // The walk moves each entry that stays ahead one slot toward the front, so the
   // search and the shift share one pass.
   assign scan_slot = slot_add(front_ff, k_ff[AW-1:0]);
   assign dst_slot  = slot_dec(scan_slot);
   assign new_entry = {pri_ff, val_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= AW'(1);
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      done_ff <= done_in;
      val_ff  <= val_in;
      pri_ff  <= pri_in;
   end

   always_comb begin
      state_in = state_ff;
      front_in = front_ff;
      count_in = count_ff;
      k_in     = k_ff;
      done_in  = done_ff;
      val_in   = val_ff;
      pri_in   = pri_ff;
      wr_en    = 1'b0;
      wr_addr  = dst_slot;
      wr_data  = new_entry;
      rd_en    = 1'b0;
      rd_addr  = scan_slot;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               val_in = req_item_value;
               pri_in = req_item_priority;
               k_in   = '0;
               if (cmd_type'(req_cmd) == CMD_DEQUEUE) begin
                  if (count_ff != '0) begin
                     front_in = slot_add(front_ff, AW'(1));
                     count_in = count_ff - CW'(1);
                     done_in  = 1'b1;
                  end else begin
                     done_in  = 1'b0;
                  end
                  state_in = ST_FRONT_RD;
               end else if (count_ff == DepthC) begin
                  done_in  = 1'b0;
                  state_in = ST_FRONT_RD;
               end else begin
                  done_in  = 1'b1;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            if (k_ff < count_ff) begin
               rd_en    = 1'b1;
               state_in = ST_SCAN_CMP;
            end else begin
               wr_en    = 1'b1;
               front_in = slot_dec(front_ff);
               count_in = count_ff + CW'(1);
               state_in = ST_FRONT_RD;
            end
         end
         ST_SCAN_CMP: begin
            wr_en = 1'b1;
            if (rd_data[ENTRY_W-1 -: PRIO_W] >= pri_ff) begin
               wr_data  = rd_data;
               k_in     = k_ff + CW'(1);
               state_in = ST_SCAN_RD;
            end else begin
               front_in = slot_dec(front_ff);
               count_in = count_ff + CW'(1);
               state_in = ST_FRONT_RD;
            end
         end
         ST_FRONT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = front_ff;
            state_in = ST_FRONT_WAIT;
         end
         ST_FRONT_WAIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = (state_ff == ST_FRONT_WAIT);
   assign rsp_done_res       = done_ff;
   assign rsp_front_value    = (count_ff == '0) ? '0 : rd_data[VALUE_W-1:0];
   assign rsp_front_priority = (count_ff == '0) ? '0 : rd_data[ENTRY_W-1 -: PRIO_W];
   assign rsp_occupancy      = count_ff;
   assign rsp_is_empty       = (count_ff == '0);
   assign rsp_is_full        = (count_ff == DepthC);

endmodule
`default_nettype wire
